// File: rtl/core/skl_pkg.sv
// Shared types and codes for the sorted key list.
// Used by the controller, the datapath and the top level; depends on nothing.
package skl_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_SEARCH = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  // Result codes.
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRST     = 3'd4,
    ST_LAST      = 3'd5,
    ST_MIDDLE    = 3'd6
  } status_t;

  // Read address choices for the key memory.
  typedef enum logic [1:0] {
    RS_IDX  = 2'd0,
    RS_DEC  = 2'd1,
    RS_INC  = 2'd2,
    RS_LAST = 2'd3
  } rsel_t;

  // Write data choices for the key memory.
  typedef enum logic {
    WS_KEY = 1'b0,
    WS_RD  = 1'b1
  } wsel_t;

  // Index register updates.
  typedef enum logic [2:0] {
    IX_HOLD  = 3'd0,
    IX_ZERO  = 3'd1,
    IX_COUNT = 3'd2,
    IX_INC   = 3'd3,
    IX_DEC   = 3'd4
  } idx_op_t;

  // Count register updates.
  typedef enum logic [1:0] {
    CN_HOLD = 2'd0,
    CN_INC  = 2'd1,
    CN_DEC  = 2'd2
  } cnt_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    wr_en;
    wsel_t   wr_sel;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    set_status;
    status_t status;
    logic    push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;
    logic  full;
    logic  idx_zero;
    logic  idx_eq_cnt;
    logic  idx_eq_last;
    logic  rd_gt;
    logic  rd_eq;
    logic  out_free;
  } sts_t;

endpackage

// File: rtl/core/skl_if.sv
// Valid/ready channel interfaces for the sorted key list.
// The request carries an operation and a key, the response a status and a count.
interface skl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

interface skl_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [4:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink (input valid, input status, input entry_count, output ready);
endinterface

// File: rtl/core/skl_datapath.sv
// Datapath of the sorted key list: key memory, index, count and result register.
// Depends on skl_pkg; driven by skl_ctrl through cmd_t and reports through sts_t.
module skl_datapath
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  req_func,
  input  logic [15:0] req_key,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        rsp_ready,
  output logic        rsp_valid,
  output logic [2:0]  rsp_status,
  output logic [4:0]  rsp_entry_count
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic [15:0]   mem [CAPACITY];
  logic [15:0]   rd_data;
  logic [15:0]   key;
  func_t         func;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic [IW-1:0] cnt;
  logic [IW-1:0] cnt_next;
  logic [IW-1:0] last;
  logic [IW-1:0] idx_dec;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] rd_addr_full;
  logic [IW+4:0] cnt_ext;
  status_t       status;

  assign last    = cnt - IW'(1);
  assign idx_dec = idx - IW'(1);
  assign idx_inc = idx + IW'(1);
  assign cnt_ext = {5'b0, cnt};

  // Captured item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= req_key;
      func <= func_t'(req_func);
    end
  end

  // Read address selection.
  always_comb begin
    case (cmd.rd_sel)
      RS_IDX:  rd_addr_full = idx;
      RS_DEC:  rd_addr_full = idx_dec;
      RS_INC:  rd_addr_full = idx_inc;
      RS_LAST: rd_addr_full = last;
      default: rd_addr_full = idx;
    endcase
  end

  // Key memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx[AW-1:0]] <= (cmd.wr_sel == WS_RD) ? rd_data : key;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr_full[AW-1:0]];
    end
  end

  // Index register.
  always_comb begin
    case (cmd.idx_op)
      IX_HOLD:  idx_next = idx;
      IX_ZERO:  idx_next = '0;
      IX_COUNT: idx_next = cnt;
      IX_INC:   idx_next = idx_inc;
      IX_DEC:   idx_next = idx_dec;
      default:  idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  // Count of held keys.
  always_comb begin
    case (cmd.cnt_op)
      CN_HOLD: cnt_next = cnt;
      CN_INC:  cnt_next = cnt + IW'(1);
      CN_DEC:  cnt_next = cnt - IW'(1);
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Result code of the item at work.
  always_ff @(posedge clk) begin
    if (cmd.set_status) begin
      status <= cmd.status;
    end
  end

  // Output register; it holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp_status      <= status;
      rsp_entry_count <= cnt_ext[4:0];
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.func        = func;
    sts.full        = (cnt == IW'(CAPACITY));
    sts.idx_zero    = (idx == '0);
    sts.idx_eq_cnt  = (idx == cnt);
    sts.idx_eq_last = (idx == last);
    sts.rd_gt       = (rd_data > key);
    sts.rd_eq       = (rd_data == key);
    sts.out_free    = !rsp_valid || rsp_ready;
  end

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= IW'(CAPACITY))
    else $error("key count above capacity");

  // The count moves by at most one per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt) || cnt == $past(cnt) + IW'(1) ||
                     cnt == $past(cnt) - IW'(1)))
    else $error("key count jumped");

  // A result is only pushed into a free output register.
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!rsp_valid || rsp_ready))
    else $error("result pushed over a waiting result");

  // Writes stay inside the store.
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> idx < IW'(CAPACITY))
    else $error("write beyond capacity");

endmodule

// File: rtl/core/skl_ctrl.sv
// Controller of the sorted key list: sequences scans and shifts of the key memory.
// Depends on skl_pkg; drives skl_datapath through cmd_t and reads sts_t back.
module skl_ctrl
  import skl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISP     = 10'b0000000010,
    S_INS_CHK  = 10'b0000000100,
    S_INS_CMP  = 10'b0000001000,
    S_SCAN_CHK = 10'b0000010000,
    S_SCAN_CMP = 10'b0000100000,
    S_SHF_CHK  = 10'b0001000000,
    S_SHF_WR   = 10'b0010000000,
    S_SRC_LAST = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_sel     = RS_IDX;
    cmd.wr_en      = 1'b0;
    cmd.wr_sel     = WS_KEY;
    cmd.idx_op     = IX_HOLD;
    cmd.cnt_op     = CN_HOLD;
    cmd.set_status = 1'b0;
    cmd.status     = ST_NOT_FOUND;
    cmd.push       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_DONE;
            end else begin
              cmd.idx_op = IX_COUNT;
              state_next = S_INS_CHK;
            end
          end
          FN_DELETE, FN_SEARCH: begin
            cmd.idx_op = IX_ZERO;
            state_next = S_SCAN_CHK;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NOT_FOUND;
            state_next     = S_DONE;
          end
        endcase
      end
      // Insert walks down from the top, moving larger keys up one place.
      S_INS_CHK: begin
        if (sts.idx_zero) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WS_KEY;
          cmd.cnt_op     = CN_INC;
          cmd.set_status = 1'b1;
          cmd.status     = ST_INSERTED;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_DEC;
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.rd_gt) begin
          cmd.wr_sel = WS_RD;
          cmd.idx_op = IX_DEC;
          state_next = S_INS_CHK;
        end else begin
          cmd.wr_sel     = WS_KEY;
          cmd.cnt_op     = CN_INC;
          cmd.set_status = 1'b1;
          cmd.status     = ST_INSERTED;
          state_next     = S_DONE;
        end
      end
      // Delete and search scan up from the bottom for the first equal key.
      S_SCAN_CHK: begin
        if (sts.idx_eq_cnt) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_IDX;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.rd_eq) begin
          if (sts.func == FN_DELETE) begin
            state_next = S_SHF_CHK;
          end else if (sts.idx_zero) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_FIRST;
            state_next     = S_DONE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RS_LAST;
            state_next = S_SRC_LAST;
          end
        end else if (sts.rd_gt) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.idx_op = IX_INC;
          state_next = S_SCAN_CHK;
        end
      end
      // Delete closes the gap by moving the keys above it down one place.
      S_SHF_CHK: begin
        if (sts.idx_eq_last) begin
          cmd.cnt_op     = CN_DEC;
          cmd.set_status = 1'b1;
          cmd.status     = ST_DELETED;
          state_next     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_INC;
          state_next = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WS_RD;
        cmd.idx_op = IX_INC;
        state_next = S_SHF_CHK;
      end
      // A match above the first entry is last or middle, by the top entry.
      S_SRC_LAST: begin
        cmd.set_status = 1'b1;
        cmd.status     = sts.rd_eq ? ST_LAST : ST_MIDDLE;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // An accepted item always leaves the idle state.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> state == S_DISP)
    else $error("accepted item not dispatched");

  // Memory is never written and read at work while idle or finishing.
  a_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !cmd.wr_en && !cmd.rd_en)
    else $error("memory access outside an operation");

  // Every push returns the block to idle.
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> state == S_IDLE)
    else $error("push did not end the operation");

endmodule

// File: rtl/core/sorted_key_list.sv
// Sorted key list: up to CAPACITY 16-bit keys in ascending order, one key memory.
// A full insert or an unused code makes no memory access; a scan, shift or insert
// steps through the memory, each step one memory read and one compare or write.
// One item at a time; the next is taken once the result is registered. Synchronous
// reset empties the list; no clearing pass.
module sorted_key_list
  import skl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  skl_req_if.sink   req,
  skl_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  skl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Storage and compare logic.
  skl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .req_func        (req.func),
    .req_key         (req.key),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted key list: directed and random operations.
// Depends on skl_pkg, the skl_req_if/skl_rsp_if channels and the sorted_key_list top.
module tb;
  import skl_pkg::*;

  localparam int DEPTH = 16;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 12;
  localparam int RANDOM_ITEMS = 1150;

  // One operation waiting to be driven, with the idle time that follows it.
  typedef struct {
    func_t       func;
    logic [15:0] key;
    int          gap;
    int          stall;
  } op_item_t;

  // One predicted result, with the receiver stall that follows its arrival.
  typedef struct {
    status_t    status;
    logic [4:0] count;
    int         stall;
  } list_result_t;

  logic clk;
  logic rst;

  skl_req_if req_ch ();
  skl_rsp_if rsp_ch ();

  sorted_key_list #(.CAPACITY(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  op_item_t     pending_ops[$];
  list_result_t awaited_results[$];

  // Predicted contents of the list.
  logic [15:0] held_keys[DEPTH];
  int          held_n;

  int errors;
  int ops_sent;
  int status_seen[8];

  always #5 clk = ~clk;

  // Applies one operation to the predicted list and returns its status.
  function automatic status_t apply_op(func_t f, logic [15:0] k);
    int      pos;
    int      i;
    status_t st;
    st = ST_NOT_FOUND;
    case (f)
      FN_INSERT: begin
        if (held_n >= DEPTH) begin
          st = ST_FULL;
        end else begin
          // New key goes after any equal keys already held.
          pos = held_n;
          for (i = held_n - 1; i >= 0; i--) begin
            if (held_keys[i] > k) pos = i;
          end
          for (i = held_n; i > pos; i--) held_keys[i] = held_keys[i - 1];
          held_keys[pos] = k;
          held_n++;
          st = ST_INSERTED;
        end
      end
      FN_DELETE: begin
        // Only the lowest matching entry is removed.
        pos = -1;
        for (i = held_n - 1; i >= 0; i--) begin
          if (held_keys[i] == k) pos = i;
        end
        if (pos >= 0) begin
          for (i = pos; i + 1 < held_n; i++) held_keys[i] = held_keys[i + 1];
          held_n--;
          st = ST_DELETED;
        end
      end
      FN_SEARCH: begin
        if (held_n > 0) begin
          if (held_keys[0] == k) begin
            st = ST_FIRST;
          end else if (held_keys[held_n - 1] == k) begin
            st = ST_LAST;
          end else begin
            for (i = 1; i + 1 < held_n; i++) begin
              if (held_keys[i] == k) st = ST_MIDDLE;
            end
          end
        end
      end
      default: st = ST_NOT_FOUND;
    endcase
    return st;
  endfunction

  task automatic queue_op(func_t f, logic [15:0] k, int gap, int stall);
    op_item_t it;
    it.func  = f;
    it.key   = k;
    it.gap   = gap;
    it.stall = stall;
    pending_ops.push_back(it);
  endtask

  // Request driver: presents queued operations and predicts each accepted one.
  int       gap_left;
  int       cur_stall;
  bit       req_busy;
  op_item_t next_op;
  list_result_t pred;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      req_busy = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        pred.status = apply_op(func_t'(req_ch.func), req_ch.key);
        pred.count  = held_n[4:0];
        pred.stall  = cur_stall;
        awaited_results.push_back(pred);
        ops_sent++;
        req_busy = 1'b0;
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.func  <= next_op.func;
          req_ch.key   <= next_op.key;
          gap_left  = next_op.gap;
          cur_stall = next_op.stall;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each accepted result against the oldest prediction.
  int           stall_left;
  list_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status %0d count %0d", $time,
                   rsp_ch.status, rsp_ch.entry_count);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     rsp_ch.status);
            errors++;
          end
          if (rsp_ch.entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.count,
                     rsp_ch.entry_count);
            errors++;
          end
          status_seen[want.status]++;
          stall_left = want.stall;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  logic [15:0] key_pool[6];
  int          made;
  int          ep_len;
  int          mode;
  bit          quiet;
  int          r;
  int          ins_pct;
  int          del_pct;
  int          gap;
  int          stall;
  func_t       f;
  logic [15:0] k;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func  = FN_NONE;
    req_ch.key   = 16'h0000;
    rsp_ch.ready = 1'b0;
    held_n   = 0;
    errors   = 0;
    ops_sent = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed: empty list, single key, equal keys, extremes of the key range.
    queue_op(FN_SEARCH, 16'h0000, 0, 0);
    queue_op(FN_DELETE, 16'h0005, 1, 0);
    queue_op(FN_NONE,   16'hFFFF, 0, 2);
    queue_op(FN_INSERT, 16'h1234, 0, 0);
    queue_op(FN_SEARCH, 16'h1234, 3, 0);
    queue_op(FN_INSERT, 16'h1234, 0, 1);
    queue_op(FN_SEARCH, 16'h1234, 0, 0);
    queue_op(FN_DELETE, 16'h1234, 0, 4);
    queue_op(FN_DELETE, 16'h1234, 2, 0);
    queue_op(FN_DELETE, 16'h1234, 0, 0);
    queue_op(FN_INSERT, 16'h0000, 0, 0);
    queue_op(FN_INSERT, 16'hFFFF, 0, 0);
    queue_op(FN_INSERT, 16'h8000, 4, 0);
    queue_op(FN_SEARCH, 16'hFFFF, 0, 3);
    queue_op(FN_SEARCH, 16'h8000, 0, 0);
    queue_op(FN_SEARCH, 16'h0000, 0, 0);
    queue_op(FN_SEARCH, 16'h7FFF, 0, 0);
    queue_op(FN_NONE,   16'h0000, 0, 0);

    // Random: episodes that grow, shrink or churn the list around a small key pool,
    // so that matches, duplicates, a full list and an emptied list all occur.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      ep_len = $urandom_range(30, 80);
      mode   = $urandom_range(0, 2);
      quiet  = ($urandom_range(0, 3) == 0);
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1)) key_pool[0] = 16'h0000;
      if ($urandom_range(0, 1)) key_pool[1] = 16'hFFFF;
      case (mode)
        0: begin ins_pct = 60; del_pct = 18; end
        1: begin ins_pct = 20; del_pct = 55; end
        default: begin ins_pct = 38; del_pct = 35; end
      endcase
      for (int n = 0; n < ep_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) f = FN_NONE;
        else if (r < 3 + ins_pct) f = FN_INSERT;
        else if (r < 3 + ins_pct + del_pct) f = FN_DELETE;
        else f = FN_SEARCH;
        r = $urandom_range(0, 99);
        if (r < 75) k = key_pool[$urandom_range(0, 5)];
        else k = 16'($urandom_range(0, 65535));
        gap   = quiet ? 0 : $urandom_range(0, 4);
        stall = quiet ? 0 : $urandom_range(0, 4);
        queue_op(f, k, gap, stall);
      end
      made += ep_len;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait for all operations to be taken and all results to arrive.
    @(posedge clk);
    while (pending_ops.size() != 0 || req_ch.valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d operations: %0d inserted, %0d full, %0d deleted, %0d not found,",
             ops_sent, status_seen[ST_INSERTED], status_seen[ST_FULL],
             status_seen[ST_DELETED], status_seen[ST_NOT_FOUND]);
    $display("  %0d found first, %0d found last, %0d found middle; %0d mismatches.",
             status_seen[ST_FIRST], status_seen[ST_LAST], status_seen[ST_MIDDLE], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d operations queued and %0d results outstanding.",
             pending_ops.size(), awaited_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
